FILE: hw/rtl/idfl_pkg.sv
// Shared types and constants for the identifier free-list allocator.
// No dependencies; imported by the top level of the block.
`timescale 1ns / 1ps
`default_nettype none
package idfl_pkg;

    localparam int POOL_SIZE = 8;
    localparam int ID_W      = 8;
    localparam int CNT_W     = $clog2(POOL_SIZE + 1);
    localparam int IDX_W     = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;

    localparam logic [1:0] CMD_ACQUIRE = 2'd0;
    localparam logic [1:0] CMD_RELEASE = 2'd1;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_EMPTY   = 2'd1,
        STATUS_REJECT  = 2'd2,
        STATUS_UNKNOWN = 2'd3
    } status_t;

    typedef enum logic {
        ST_IDLE,
        ST_POP
    } fsm_state_t;

    typedef struct packed {
        logic [1:0]      command;
        logic [ID_W-1:0] release_id;
    } req_word_t;

    typedef struct packed {
        logic [ID_W-1:0] granted_id;
        status_t         status;
    } rsp_word_t;

endpackage
`default_nettype wire

FILE: hw/rtl/idfl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; holds the free-identifier stack.
`timescale 1ns / 1ps
`default_nettype none
module idfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/id_free_list_allocator_unit.sv
// Top level of the identifier free-list allocator.
// Depends on idfl_pkg and idfl_ram.
// Release, unknown commands and an acquire from an empty pool write their result
// straight into the output register. An acquire from a non-empty pool first goes
// through the pop state, because the top of the free stack is read from a RAM with
// registered read data, and the input stalls in that state. Otherwise a new request
// word is taken while the previous result still sits in the output register, as long
// as that register is free or drains that cycle. The stack RAM needs no clearing pass:
// per-entry written bits make an unwritten entry read as its reset identifier.
`timescale 1ns / 1ps
`default_nettype none
module id_free_list_allocator_unit
    import idfl_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire req_word_t in_word,
    output logic           out_valid,
    input  wire logic      out_stall,
    output rsp_word_t      out_word
);

    fsm_state_t state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [POOL_SIZE-1:0] taken_reg, taken_next;
    logic [POOL_SIZE-1:0] written_reg, written_next;
    logic                 out_valid_reg, out_valid_next;
    rsp_word_t            out_word_reg, out_word_next;
    logic                 rd_written_reg, rd_written_next;
    logic [IDX_W-1:0]     rd_idx_reg, rd_idx_next;

    logic             in_accept;
    logic             ram_we, ram_re;
    logic [IDX_W-1:0] ram_waddr, ram_raddr;
    logic [ID_W-1:0]  ram_rdata;
    logic [ID_W-1:0]  rid_m1;
    logic [IDX_W-1:0] rid_idx;
    logic             rid_ok;
    logic [ID_W-1:0]  pop_id, pop_id_m1;
    logic [IDX_W-1:0] top_idx, push_idx;

    idfl_ram #(
        .WIDTH(ID_W),
        .DEPTH(POOL_SIZE)
    ) u_stack (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(in_word.release_id),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign in_stall  = (state_reg != ST_IDLE) || (out_valid_reg && out_stall);
    assign in_accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    assign rid_m1   = in_word.release_id - ID_W'(1);
    assign rid_idx  = rid_m1[IDX_W-1:0];
    assign top_idx  = IDX_W'(count_reg - CNT_W'(1));
    assign push_idx = IDX_W'(count_reg);
    assign rid_ok   = (in_word.release_id >= ID_W'(1))
                   && (in_word.release_id <= ID_W'(POOL_SIZE))
                   && taken_reg[rid_idx]
                   && (count_reg < CNT_W'(POOL_SIZE));

    assign pop_id    = rd_written_reg ? ram_rdata : (ID_W'(rd_idx_reg) + ID_W'(1));
    assign pop_id_m1 = pop_id - ID_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= CNT_W'(POOL_SIZE);
            taken_reg     <= '0;
            written_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            taken_reg     <= taken_next;
            written_reg   <= written_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg   <= out_word_next;
        rd_written_reg <= rd_written_next;
        rd_idx_reg     <= rd_idx_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        taken_next      = taken_reg;
        written_next    = written_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_word_next   = out_word_reg;
        rd_written_next = rd_written_reg;
        rd_idx_next     = rd_idx_reg;
        ram_we          = 1'b0;
        ram_waddr       = push_idx;
        ram_re          = 1'b0;
        ram_raddr       = top_idx;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    priority if (in_word.command == CMD_ACQUIRE)
                    begin
                        if (count_reg == '0)
                        begin
                            out_valid_next = 1'b1;
                            out_word_next  = '{granted_id: '0, status: STATUS_EMPTY};
                        end
                        else
                        begin
                            ram_re          = 1'b1;
                            rd_idx_next     = top_idx;
                            rd_written_next = written_reg[top_idx];
                            state_next      = ST_POP;
                        end
                    end
                    else if (in_word.command == CMD_RELEASE)
                    begin
                        out_valid_next = 1'b1;
                        if (rid_ok)
                        begin
                            ram_we                 = 1'b1;
                            written_next[push_idx] = 1'b1;
                            taken_next[rid_idx]    = 1'b0;
                            count_next             = count_reg + CNT_W'(1);
                            out_word_next = '{granted_id: '0, status: STATUS_OK};
                        end
                        else
                        begin
                            out_word_next = '{granted_id: '0, status: STATUS_REJECT};
                        end
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        out_word_next  = '{granted_id: '0, status: STATUS_UNKNOWN};
                    end
                end
            end
            ST_POP:
            begin
                count_next = count_reg - CNT_W'(1);
                if ((pop_id >= ID_W'(1)) && (pop_id <= ID_W'(POOL_SIZE)))
                begin
                    taken_next[pop_id_m1[IDX_W-1:0]] = 1'b1;
                end
                out_valid_next = 1'b1;
                out_word_next  = '{granted_id: pop_id, status: STATUS_OK};
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(POOL_SIZE))
        else $error("free count above pool size");

    a_pool_balance: assert property (@(posedge clk) disable iff (!rst_n)
        (32'($countones(taken_reg)) + 32'(count_reg)) == 32'(POOL_SIZE))
        else $error("acquired bits and free count disagree");

    a_pop_after_acquire: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POP) |-> $past(in_accept && (in_word.command == CMD_ACQUIRE)))
        else $error("pop without an accepted acquire");

    a_pop_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POP) |-> !out_valid_reg)
        else $error("output register busy during pop");

    a_pop_returns: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POP) |=> (state_reg == ST_IDLE) && out_valid_reg)
        else $error("pop did not produce a result");

endmodule
`default_nettype wire
